@@ src/dhoam_pkg.sv @@
package dhoam_pkg;

  localparam int unsigned TableSize = 1021;
  localparam int unsigned SlotW = $clog2(TableSize);
  localparam int unsigned CountW = 10;
  localparam int unsigned LoadW = 7;

  localparam logic [31:0] SeedStart = 32'h378b0322;
  localparam logic [31:0] SeedStep = 32'h9fa770ba;
  localparam logic [6:0] LoadReset = 7'd75;

  typedef enum logic [1:0] {
    KindInsert = 2'd0,
    KindRemove = 2'd1,
    KindLookup = 2'd2,
    KindClear = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StatDone = 2'd0,
    StatMiss = 2'd1,
    StatFull = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MarkEmpty = 2'd0,
    MarkUsed = 2'd1,
    MarkTomb = 2'd2
  } mark_e;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StHash1,
    StHash2,
    StHash3,
    StHash4,
    StReduce,
    StIssue,
    StWait,
    StCheck,
    StFree,
    StFreeWait,
    StFreeCheck,
    StDone
  } state_e;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

endpackage

@@ src/dhoam_ram.sv @@
module dhoam_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/double_hash_open_address_map.sv @@
// Double-hashed open-addressing key/value table, 1021 slots, 32-bit keys/values.
// Command channel: present kind_i/key_i/value_i with start_i; the transaction is
// taken when start_i is high and busy_o is low. busy_o stays high until the
// result has been presented.
// Result channel: done_o pulses for one cycle with status_o, found_o,
// read_value_o and live_entries_o. The receiver cannot stall; it must sample.
// Steps: the first key multiply happens at acceptance, then the hash states
// StHash1 to StHash4, StReduce and StIssue, then per probe a registered read
// of the slot memory (StWait) and a compare (StCheck). Inserts of new keys
// below the load limit add a second probe walk: StFree, then StFreeWait and
// StFreeCheck per probe. A walk is bounded to 1021 probes. The next
// transaction can be taken in the cycle after done_o.
// Clear sweeps all 1021 marks one per cycle, then raises done_o.
// Reset: the block sweeps the mark memory to empty with busy_o high; config
// writes are accepted throughout. load_percent resets to 75.
// APB register 0 at address 0: load_percent[6:0].
module double_hash_open_address_map (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic signed [31:0] read_value_o,
  output logic [9:0]  live_entries_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SW = dhoam_pkg::SlotW;

  dhoam_pkg::state_e state_q, state_d;
  logic [6:0] load_q;
  logic [1:0] kind_q;
  logic [31:0] key_q, val_q;
  logic [31:0] ha_q, hb_q;
  logic [SW-1:0] start_q, step_q, pos_q, pos_d;
  logic [SW:0] n_q, n_d;
  logic [dhoam_pkg::CountW-1:0] used_q, used_d;
  logic [1:0] stat_q, stat_d;
  logic found_q, found_d;
  logic [31:0] rd_q, rd_d;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {25'd0, load_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= dhoam_pkg::LoadReset;
    end else if (psel && penable && pwrite && pready && paddr == 2'd0) begin
      load_q <= pwdata[6:0];
    end
  end

  // memories
  logic mark_we, kv_we;
  logic [SW-1:0] mark_wa, raddr;
  logic [1:0] mark_wd, mark_rd;
  logic [63:0] kv_rd;

  dhoam_ram #(.Width(2), .Depth(dhoam_pkg::TableSize)) u_mark (
    .clk_i, .we_i(mark_we), .waddr_i(mark_wa), .wdata_i(mark_wd),
    .raddr_i(raddr), .rdata_o(mark_rd)
  );
  dhoam_ram #(.Width(64), .Depth(dhoam_pkg::TableSize)) u_kv (
    .clk_i, .we_i(kv_we), .waddr_i(mark_wa), .wdata_i({key_q, val_q}),
    .raddr_i(raddr), .rdata_o(kv_rd)
  );

  assign raddr = pos_q;

  // hash stages
  logic [31:0] k1, ha1, hb1, fa, fb;
  assign k1 = dhoam_pkg::rotl(ha_q, 15) * 32'h1b873593;
  always_comb begin
    ha1 = dhoam_pkg::rotl(dhoam_pkg::SeedStart ^ ha_q, 13) * 32'd5 + 32'he6546b64;
    hb1 = dhoam_pkg::rotl(dhoam_pkg::SeedStep ^ ha_q, 13) * 32'd5 + 32'he6546b64;
    ha1 = ha1 ^ 32'd4;
    hb1 = hb1 ^ 32'd4;
    ha1 = ha1 ^ (ha1 >> 16);
    hb1 = hb1 ^ (hb1 >> 16);
  end
  assign fa = ha_q ^ (ha_q >> 16);
  assign fb = hb_q ^ (hb_q >> 16);

  // mod 1021 by reciprocal: x - floor(x*q)*1021
  function automatic logic [SW-1:0] mod_t(input logic [31:0] x);
    logic [63:0] p;
    logic [31:0] qt, r;
    p = {32'd0, x} * 64'd4206628;
    qt = p[63:32];
    r = x - qt * 32'd1021;
    while_fix: begin
      if (r >= 32'd1021) r = r - 32'd1021;
      if (r >= 32'd1021) r = r - 32'd1021;
    end
    mod_t = r[SW-1:0];
  endfunction

  // next probe: pos + step mod size
  logic [SW:0] nxt_sum;
  logic [SW-1:0] nxt_pos;
  assign nxt_sum = {1'b0, pos_q} + {1'b0, step_q};
  assign nxt_pos = (nxt_sum >= (SW+1)'(dhoam_pkg::TableSize)) ?
                   SW'(nxt_sum - (SW+1)'(dhoam_pkg::TableSize)) : nxt_sum[SW-1:0];

  logic hit, limit;
  assign hit = (mark_rd == dhoam_pkg::MarkUsed) && (kv_rd[63:32] == key_q);
  assign limit = ({7'd0, used_q} + 17'd1) * 17'd100 >=
                 17'(dhoam_pkg::TableSize) * {10'd0, load_q};

  always_comb begin
    state_d = state_q;
    pos_d = pos_q;
    n_d = n_q;
    case (state_q)
      dhoam_pkg::StIdle: if (start_i) begin
        state_d = (kind_i == dhoam_pkg::KindClear) ? dhoam_pkg::StClear : dhoam_pkg::StHash1;
        pos_d = '0;
      end
      dhoam_pkg::StClear: begin
        pos_d = pos_q + SW'(1);
        if (pos_q == SW'(dhoam_pkg::TableSize - 1)) begin
          state_d = (kind_q == dhoam_pkg::KindClear) ? dhoam_pkg::StDone : dhoam_pkg::StIdle;
        end
      end
      dhoam_pkg::StHash1: state_d = dhoam_pkg::StHash2;
      dhoam_pkg::StHash2: state_d = dhoam_pkg::StHash3;
      dhoam_pkg::StHash3: state_d = dhoam_pkg::StHash4;
      dhoam_pkg::StHash4: state_d = dhoam_pkg::StReduce;
      dhoam_pkg::StReduce: state_d = dhoam_pkg::StIssue;
      dhoam_pkg::StIssue: begin
        pos_d = start_q;
        n_d = '0;
        state_d = dhoam_pkg::StWait;
      end
      dhoam_pkg::StWait: state_d = dhoam_pkg::StCheck;
      dhoam_pkg::StCheck: begin
        if (mark_rd == dhoam_pkg::MarkEmpty || hit ||
            n_q == (SW+1)'(dhoam_pkg::TableSize - 1)) begin
          if (!hit && kind_q == dhoam_pkg::KindInsert && !limit) begin
            state_d = dhoam_pkg::StFree;
          end else begin
            state_d = dhoam_pkg::StDone;
          end
        end else begin
          pos_d = nxt_pos;
          n_d = n_q + (SW+1)'(1);
          state_d = dhoam_pkg::StWait;
        end
      end
      dhoam_pkg::StFree: begin
        pos_d = start_q;
        n_d = '0;
        state_d = dhoam_pkg::StFreeWait;
      end
      dhoam_pkg::StFreeWait: state_d = dhoam_pkg::StFreeCheck;
      dhoam_pkg::StFreeCheck: begin
        if (mark_rd != dhoam_pkg::MarkUsed || n_q == (SW+1)'(dhoam_pkg::TableSize - 1)) begin
          state_d = dhoam_pkg::StDone;
        end else begin
          pos_d = nxt_pos;
          n_d = n_q + (SW+1)'(1);
          state_d = dhoam_pkg::StFreeWait;
        end
      end
      dhoam_pkg::StDone: state_d = dhoam_pkg::StIdle;
      default: state_d = dhoam_pkg::StIdle;
    endcase
  end

  always_comb begin
    mark_we = 1'b0;
    kv_we = 1'b0;
    mark_wa = pos_q;
    mark_wd = dhoam_pkg::MarkEmpty;
    used_d = used_q;
    stat_d = stat_q;
    found_d = found_q;
    rd_d = rd_q;
    case (state_q)
      dhoam_pkg::StIdle: begin
        stat_d = dhoam_pkg::StatDone;
        found_d = 1'b0;
        rd_d = '0;
      end
      dhoam_pkg::StClear: begin
        mark_we = 1'b1;
        used_d = '0;
      end
      dhoam_pkg::StCheck: begin
        if (hit) begin
          found_d = 1'b1;
          case (kind_q)
            dhoam_pkg::KindInsert: begin
              kv_we = 1'b1;
            end
            dhoam_pkg::KindRemove: begin
              mark_we = 1'b1;
              mark_wd = dhoam_pkg::MarkTomb;
              used_d = used_q - (dhoam_pkg::CountW)'(1);
            end
            dhoam_pkg::KindLookup: rd_d = kv_rd[31:0];
            default: ;
          endcase
        end else if (mark_rd == dhoam_pkg::MarkEmpty ||
                     n_q == (SW+1)'(dhoam_pkg::TableSize - 1)) begin
          stat_d = (kind_q == dhoam_pkg::KindInsert) ? dhoam_pkg::StatFull :
                   dhoam_pkg::StatMiss;
        end
      end
      dhoam_pkg::StFreeCheck: begin
        if (mark_rd != dhoam_pkg::MarkUsed) begin
          mark_we = 1'b1;
          mark_wd = dhoam_pkg::MarkUsed;
          kv_we = 1'b1;
          used_d = used_q + (dhoam_pkg::CountW)'(1);
          stat_d = dhoam_pkg::StatDone;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dhoam_pkg::StClear;
      kind_q <= dhoam_pkg::KindInsert;
      pos_q <= '0;
      n_q <= '0;
      used_q <= '0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d;
      n_q <= n_d;
      used_q <= used_d;
      if (state_q == dhoam_pkg::StIdle && start_i) kind_q <= kind_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q <= stat_d;
    found_q <= found_d;
    rd_q <= rd_d;
    if (state_q == dhoam_pkg::StIdle && start_i) begin
      key_q <= key_i;
      val_q <= value_i;
    end
    case (state_q)
      dhoam_pkg::StIdle: begin
        if (start_i) ha_q <= key_i * 32'hcc9e2d51;
      end
      dhoam_pkg::StHash1: ha_q <= k1;
      dhoam_pkg::StHash2: begin
        hb_q <= hb1 * 32'h85ebca6b;
        ha_q <= ha1 * 32'h85ebca6b;
      end
      dhoam_pkg::StHash3: begin
        ha_q <= (ha_q ^ (ha_q >> 13)) * 32'hc2b2ae35;
        hb_q <= (hb_q ^ (hb_q >> 13)) * 32'hc2b2ae35;
      end
      dhoam_pkg::StHash4: begin
        ha_q <= fa;
        hb_q <= fb;
      end
      dhoam_pkg::StReduce: begin
        start_q <= mod_t(ha_q);
        step_q <= (mod_t(hb_q) == '0) ? SW'(1) : mod_t(hb_q);
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != dhoam_pkg::StIdle);
  assign done_o = (state_q == dhoam_pkg::StDone);
  assign status_o = stat_q;
  assign found_o = found_q;
  assign read_value_o = rd_q;
  assign live_entries_o = used_q;

endmodule
